FILE: hw/rtl/mou_pkg.sv
`timescale 1ns / 1ps

package mou_pkg;

  // operation codes
  typedef enum logic [2:0] {
    OP_BYTE_LOAD   = 3'd0,
    OP_BYTE_STORE  = 3'd1,
    OP_WORD_LOAD   = 3'd2,
    OP_WORD_STORE  = 3'd3,
    OP_SEG_LOAD    = 3'd4,
    OP_SEG_STORE   = 3'd5,
    OP_HOST_WRITE  = 3'd6,
    OP_HOST_READ   = 3'd7
  } op_t;

  // segment prefix codes
  localparam logic [2:0] PFX_NONE = 3'd0;
  localparam logic [2:0] PFX_CS   = 3'd1;
  localparam logic [2:0] PFX_DS   = 3'd2;
  localparam logic [2:0] PFX_ES   = 3'd3;
  localparam logic [2:0] PFX_SS   = 3'd4;

  // segment register select, offset from SREG_BASE in the register file
  localparam logic [1:0] SREG_ES = 2'd0;
  localparam logic [1:0] SREG_CS = 2'd1;
  localparam logic [1:0] SREG_SS = 2'd2;
  localparam logic [1:0] SREG_DS = 2'd3;

  localparam int NUM_REGS = 12;
  localparam int REG_IDX_BITS = $clog2(NUM_REGS);
  localparam logic [REG_IDX_BITS-1:0] SREG_BASE = REG_IDX_BITS'(8);
  localparam logic [REG_IDX_BITS-1:0] HOST_INDEX_LAST = REG_IDX_BITS'(NUM_REGS - 1);

  localparam logic [REG_IDX_BITS-1:0] REG_BX = REG_IDX_BITS'(3);
  localparam logic [REG_IDX_BITS-1:0] REG_BP = REG_IDX_BITS'(5);
  localparam logic [REG_IDX_BITS-1:0] REG_SI = REG_IDX_BITS'(6);
  localparam logic [REG_IDX_BITS-1:0] REG_DI = REG_IDX_BITS'(7);

  localparam logic [1:0] MOD_NODISP = 2'b00;
  localparam logic [1:0] MOD_DISP8  = 2'b01;
  localparam logic [1:0] MOD_REG    = 2'b11;
  localparam logic [2:0] RM_DIRECT  = 3'b110;

  localparam logic [15:0] HI_MASK = 16'hff00;
  localparam logic [15:0] LO_MASK = 16'h00ff;

  localparam int SEG_SHIFT = 4;
  localparam int PHYS_BITS = 16 + SEG_SHIFT;
  localparam int ADDR_BITS_DEFAULT = 16;

  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CNT_BITS = $clog2(QUEUE_DEPTH + 1);

  localparam int IN_DATA_BITS  = 56;
  localparam int OUT_DATA_BITS = 40;

  // classified item, front to back
  typedef struct packed {
    op_t                     op;
    logic [1:0]              mode;
    logic [2:0]              reg_sel;
    logic [2:0]              rm;
    logic [15:0]             disp;
    logic [1:0]              seg_sel;
    logic [REG_IDX_BITS-1:0] host_index;
    logic [15:0]             host_value;
    logic                    is_host;
    logic                    is_reg;
    logic                    is_fail;
  } entry_t;

  typedef struct packed {
    logic        ok;
    logic [15:0] moved_value;
    logic [15:0] effective_address;
    logic        operand_in_register;
  } result_t;

endpackage

FILE: hw/rtl/mou_ram.sv
`timescale 1ns / 1ps

module mou_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

FILE: hw/rtl/mou_front.sv
`timescale 1ns / 1ps

module mou_front (
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // opcode, modrm_byte, displacement, segment_prefix, host_index, host_value
  input  logic [mou_pkg::IN_DATA_BITS-1:0]    s_tdata,
  input  logic                                full,
  output logic                                push,
  output mou_pkg::entry_t                     entry
);

  logic [2:0]      pfx;
  logic [7:0]      modrm;
  logic            pfx_bad;
  logic [1:0]      seg_sel;
  mou_pkg::op_t    op;

  assign op    = mou_pkg::op_t'(s_tdata[2:0]);
  assign modrm = s_tdata[10:3];
  assign pfx   = s_tdata[29:27];

  always_comb begin
    pfx_bad = 1'b0;
    seg_sel = mou_pkg::SREG_DS;
    case (pfx)
      mou_pkg::PFX_NONE, mou_pkg::PFX_DS: seg_sel = mou_pkg::SREG_DS;
      mou_pkg::PFX_CS: seg_sel = mou_pkg::SREG_CS;
      mou_pkg::PFX_ES: seg_sel = mou_pkg::SREG_ES;
      mou_pkg::PFX_SS: seg_sel = mou_pkg::SREG_SS;
      default: pfx_bad = 1'b1;
    endcase
  end

  always_comb begin
    entry            = '0;
    entry.op         = op;
    entry.mode       = modrm[7:6];
    entry.reg_sel    = modrm[5:3];
    entry.rm         = modrm[2:0];
    entry.disp       = s_tdata[26:11];
    entry.seg_sel    = seg_sel;
    entry.host_index = s_tdata[33:30];
    entry.host_value = s_tdata[49:34];
    entry.is_host    = op inside {mou_pkg::OP_HOST_WRITE, mou_pkg::OP_HOST_READ};
    entry.is_reg     = !entry.is_host && (entry.mode == mou_pkg::MOD_REG);
    // prefix only matters for a memory operand
    if (entry.is_host) begin
      entry.is_fail = entry.host_index > mou_pkg::HOST_INDEX_LAST;
    end else begin
      entry.is_fail = (!entry.is_reg && pfx_bad)
                   || ((op inside {mou_pkg::OP_SEG_LOAD, mou_pkg::OP_SEG_STORE})
                       && entry.reg_sel[2]);
    end
  end

  assign s_tready = !full;
  assign push     = s_tvalid && !full;

endmodule

FILE: hw/rtl/mou_queue.sv
`timescale 1ns / 1ps

module mou_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  mou_pkg::entry_t din,
  output logic            full,
  input  logic            pop,
  output mou_pkg::entry_t dout,
  output logic            valid
);

  localparam int PB = mou_pkg::QUEUE_PTR_BITS;
  localparam int CB = mou_pkg::QUEUE_CNT_BITS;

  mou_pkg::entry_t entries [mou_pkg::QUEUE_DEPTH];
  logic [PB-1:0]   wr_ptr;
  logic [PB-1:0]   rd_ptr;
  logic [CB-1:0]   count;

  assign full  = count == CB'(mou_pkg::QUEUE_DEPTH);
  assign valid = count != '0;
  assign dout  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PB'(mou_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PB'(mou_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= din;
    end
  end

endmodule

FILE: hw/rtl/mou_back.sv
`timescale 1ns / 1ps

module mou_back #(
  parameter int ADDR_BITS = mou_pkg::ADDR_BITS_DEFAULT
) (
  input  logic              clk,
  input  logic              rst,
  input  mou_pkg::entry_t   head,
  input  logic              head_valid,
  output logic              pop,
  output logic              m_tvalid,
  input  logic              m_tready,
  output mou_pkg::result_t  result
);

  localparam int RB = mou_pkg::REG_IDX_BITS;

  typedef enum logic [1:0] {
    ST_EXEC,
    ST_MEM0,
    ST_MEM1,
    ST_MEM2
  } state_t;

  typedef struct packed {
    logic          en;
    logic [RB-1:0] idx;
    logic          hi;
    logic          lo;
    logic [15:0]   data;
  } rf_wr_t;

  state_t            state;
  state_t            state_next;
  logic [15:0]       rf [mou_pkg::NUM_REGS];
  rf_wr_t            wr;

  mou_pkg::entry_t   cur;
  mou_pkg::entry_t   cur_next;
  mou_pkg::entry_t   src;
  logic [15:0]       ea_q;
  logic [15:0]       ea_next;
  logic [15:0]       seg_q;
  logic [15:0]       seg_next;
  logic [15:0]       val_q;
  logic [15:0]       val_next;
  logic [7:0]        lo_q;
  logic [7:0]        lo_next;

  logic              out_free;
  logic              out_load;
  mou_pkg::result_t  res;
  logic [15:0]       mv;

  logic              head_is_mem;
  logic              cur_is_store;
  logic [RB-1:0]     rd_idx;
  logic              rd_hi;
  logic [15:0]       rd_word;
  logic [7:0]        rd_byte;
  logic [RB-1:0]     dst_idx;
  logic              dst_byte;
  logic              dst_hi;

  logic [15:0]       base_a;
  logic [15:0]       base_b;
  logic [15:0]       disp_ext;
  logic [15:0]       ea_calc;

  logic [15:0]       offset;
  logic [mou_pkg::PHYS_BITS-1:0] phys;
  logic              ram_en;
  logic              ram_we;
  logic [7:0]        ram_wdata;
  logic [7:0]        ram_rdata;

  assign out_free     = !m_tvalid || m_tready;
  assign head_is_mem  = !(head.is_host || head.is_reg || head.is_fail);
  assign cur_is_store = cur.op inside {mou_pkg::OP_BYTE_STORE, mou_pkg::OP_WORD_STORE,
                                       mou_pkg::OP_SEG_STORE};
  assign src          = (state == ST_EXEC) ? head : cur;

  // operand and segment read port of the register file; the address bases are read directly
  always_comb begin
    rd_hi  = 1'b0;
    rd_idx = src.host_index;
    if (state == ST_EXEC && head_is_mem) begin
      rd_idx = mou_pkg::SREG_BASE | {2'b00, head.seg_sel};
    end else if (!src.is_host) begin
      case (src.op)
        mou_pkg::OP_BYTE_LOAD: begin
          rd_idx = {2'b00, src.rm[1:0]};
          rd_hi  = src.rm[2];
        end
        mou_pkg::OP_BYTE_STORE: begin
          rd_idx = {2'b00, src.reg_sel[1:0]};
          rd_hi  = src.reg_sel[2];
        end
        mou_pkg::OP_WORD_LOAD, mou_pkg::OP_SEG_LOAD: rd_idx = {1'b0, src.rm};
        mou_pkg::OP_WORD_STORE: rd_idx = {1'b0, src.reg_sel};
        mou_pkg::OP_SEG_STORE: rd_idx = mou_pkg::SREG_BASE | {2'b00, src.reg_sel[1:0]};
        default: rd_idx = src.host_index;
      endcase
    end
  end

  assign rd_word = rf[rd_idx];
  assign rd_byte = rd_hi ? rd_word[15:8] : rd_word[7:0];

  // destination of the register write
  always_comb begin
    dst_byte = 1'b0;
    dst_hi   = 1'b0;
    dst_idx  = src.host_index;
    case (src.op)
      mou_pkg::OP_BYTE_LOAD: begin
        dst_idx  = {2'b00, src.reg_sel[1:0]};
        dst_byte = 1'b1;
        dst_hi   = src.reg_sel[2];
      end
      mou_pkg::OP_BYTE_STORE: begin
        dst_idx  = {2'b00, src.rm[1:0]};
        dst_byte = 1'b1;
        dst_hi   = src.rm[2];
      end
      mou_pkg::OP_WORD_LOAD: dst_idx = {1'b0, src.reg_sel};
      mou_pkg::OP_SEG_LOAD: dst_idx = mou_pkg::SREG_BASE | {2'b00, src.reg_sel[1:0]};
      mou_pkg::OP_WORD_STORE, mou_pkg::OP_SEG_STORE: dst_idx = {1'b0, src.rm};
      default: dst_idx = src.host_index;
    endcase
  end

  // effective address of the item at the head of the queue
  always_comb begin
    base_a = '0;
    base_b = '0;
    case (head.rm)
      3'd0, 3'd1, 3'd2, 3'd3: begin
        base_a = head.rm[1] ? rf[mou_pkg::REG_BP] : rf[mou_pkg::REG_BX];
        base_b = head.rm[0] ? rf[mou_pkg::REG_DI] : rf[mou_pkg::REG_SI];
      end
      3'd4: base_b = rf[mou_pkg::REG_SI];
      3'd5: base_b = rf[mou_pkg::REG_DI];
      3'd6: base_a = rf[mou_pkg::REG_BP];
      default: base_a = rf[mou_pkg::REG_BX];
    endcase
    case (head.mode)
      mou_pkg::MOD_NODISP: disp_ext = '0;
      mou_pkg::MOD_DISP8: disp_ext = {{8{head.disp[7]}}, head.disp[7:0]};
      default: disp_ext = head.disp;
    endcase
    if (head.is_reg || head.is_host) begin
      ea_calc = '0;
    end else if (head.mode == mou_pkg::MOD_NODISP && head.rm == mou_pkg::RM_DIRECT) begin
      ea_calc = head.disp;
    end else begin
      ea_calc = base_a + base_b + disp_ext;
    end
  end

  // second byte of a word wraps inside the segment
  assign offset = (state == ST_MEM1) ? ea_q + 16'd1 : ea_q;
  assign phys   = {seg_q, {mou_pkg::SEG_SHIFT{1'b0}}}
                + {{mou_pkg::SEG_SHIFT{1'b0}}, offset};

  always_comb begin
    state_next = state;
    pop        = 1'b0;
    out_load   = 1'b0;
    mv         = '0;
    res        = '0;
    wr         = '0;
    ram_en     = 1'b0;
    ram_we     = 1'b0;
    ram_wdata  = '0;
    cur_next   = cur;
    ea_next    = ea_q;
    seg_next   = seg_q;
    val_next   = val_q;
    lo_next    = lo_q;
    case (state)
      ST_EXEC: begin
        if (head_valid) begin
          if (!head_is_mem) begin
            if (out_free) begin
              pop      = 1'b1;
              out_load = 1'b1;
              if (!head.is_fail) begin
                if (head.op == mou_pkg::OP_HOST_WRITE) begin
                  mv = head.host_value;
                end else if (dst_byte) begin
                  mv = {8'h00, rd_byte};
                end else begin
                  mv = rd_word;
                end
                wr.en = head.op != mou_pkg::OP_HOST_READ;
              end
              res.ok                  = !head.is_fail;
              res.effective_address   = ea_calc;
              res.operand_in_register = head.is_reg;
            end
          end else begin
            pop        = 1'b1;
            cur_next   = head;
            ea_next    = ea_calc;
            seg_next   = rd_word;
            state_next = ST_MEM0;
          end
        end
      end
      ST_MEM0: begin
        ram_en = 1'b1;
        if (cur_is_store) begin
          mv        = (cur.op == mou_pkg::OP_BYTE_STORE) ? {8'h00, rd_byte} : rd_word;
          ram_we    = 1'b1;
          ram_wdata = mv[7:0];
          if (cur.op != mou_pkg::OP_BYTE_STORE) begin
            val_next   = mv;
            state_next = ST_MEM1;
          end else if (out_free) begin
            out_load   = 1'b1;
            state_next = ST_EXEC;
          end
        end else begin
          state_next = ST_MEM1;
        end
      end
      ST_MEM1: begin
        if (cur.op == mou_pkg::OP_BYTE_LOAD) begin
          if (out_free) begin
            mv         = {8'h00, ram_rdata};
            wr.en      = 1'b1;
            out_load   = 1'b1;
            state_next = ST_EXEC;
          end
        end else if (cur_is_store) begin
          if (out_free) begin
            ram_en     = 1'b1;
            ram_we     = 1'b1;
            ram_wdata  = val_q[15:8];
            mv         = val_q;
            out_load   = 1'b1;
            state_next = ST_EXEC;
          end
        end else begin
          ram_en     = 1'b1;
          lo_next    = ram_rdata;
          state_next = ST_MEM2;
        end
      end
      ST_MEM2: begin
        if (out_free) begin
          mv         = {ram_rdata, lo_q};
          wr.en      = 1'b1;
          out_load   = 1'b1;
          state_next = ST_EXEC;
        end
      end
      default: state_next = ST_EXEC;
    endcase
    if (state != ST_EXEC) begin
      res.ok                = 1'b1;
      res.effective_address = ea_q;
    end
    res.moved_value = mv;
    wr.idx  = dst_idx;
    wr.hi   = !dst_byte || dst_hi;
    wr.lo   = !dst_byte || !dst_hi;
    wr.data = dst_byte ? {mv[7:0], mv[7:0]} : mv;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_EXEC;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (out_load) begin
        m_tvalid <= 1'b1;
        result   <= res;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    cur   <= cur_next;
    ea_q  <= ea_next;
    seg_q <= seg_next;
    val_q <= val_next;
    lo_q  <= lo_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < mou_pkg::NUM_REGS; i++) begin
        rf[i] <= '0;
      end
    end else if (wr.en) begin
      if (wr.hi) begin
        rf[wr.idx][15:8] <= wr.data[15:8];
      end
      if (wr.lo) begin
        rf[wr.idx][7:0] <= wr.data[7:0];
      end
    end
  end

  mou_ram #(
    .WIDTH (8),
    .DEPTH (2 ** ADDR_BITS)
  ) u_ram (
    .clk   (clk),
    .en    (ram_en),
    .we    (ram_we),
    .addr  (phys[ADDR_BITS-1:0]),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

`ifndef SYNTHESIS
  a_wr_with_result: assert property (@(posedge clk) disable iff (rst)
    wr.en |-> out_load)
    else $error("register write without a result");

  a_fail_no_effect: assert property (@(posedge clk) disable iff (rst)
    (out_load && !res.ok) |-> (!wr.en && !(ram_en && ram_we)))
    else $error("failed item changed state");

  a_mem_write_store: assert property (@(posedge clk) disable iff (rst)
    (ram_en && ram_we) |-> (state != ST_EXEC && (cur.op == mou_pkg::OP_BYTE_STORE
      || cur.op == mou_pkg::OP_WORD_STORE || cur.op == mou_pkg::OP_SEG_STORE)))
    else $error("memory write outside a store");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    out_load |-> (!m_tvalid || m_tready))
    else $error("pending result overwritten");

  a_reset_idle: assert property (@(posedge clk)
    $past(rst) |-> (state == ST_EXEC && !m_tvalid))
    else $error("not idle after reset");
`endif

endmodule

FILE: hw/rtl/modrm_operand_unit.sv
`timescale 1ns / 1ps
// register, host and failed items end in ST_EXEC, a byte store in ST_MEM0, a byte
// load or word store in ST_MEM1, a word load in ST_MEM2; one item per cycle for
// register and host items while the output is free, memory items hold the sequencer
// until done (single-port byte ram); a two-entry queue parts decoder and sequencer
// reset: synchronous, clears the register file, queue and output valid; ram has none

module modrm_operand_unit #(
  parameter int ADDR_BITS = mou_pkg::ADDR_BITS_DEFAULT
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  // opcode, modrm_byte, displacement, segment_prefix, host_index, host_value
  input  logic [mou_pkg::IN_DATA_BITS-1:0]   s_tdata,
  output logic                               m_tvalid,
  input  logic                               m_tready,
  // ok, moved_value, effective_address, operand_in_register
  output logic [mou_pkg::OUT_DATA_BITS-1:0]  m_tdata
);

  mou_pkg::entry_t  push_entry;
  mou_pkg::entry_t  head;
  mou_pkg::result_t result;
  logic             push;
  logic             full;
  logic             pop;
  logic             head_valid;

  mou_front u_front (
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .full     (full),
    .push     (push),
    .entry    (push_entry)
  );

  mou_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .din   (push_entry),
    .full  (full),
    .pop   (pop),
    .dout  (head),
    .valid (head_valid)
  );

  mou_back #(
    .ADDR_BITS (ADDR_BITS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .head_valid (head_valid),
    .pop        (pop),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .result     (result)
  );

  assign m_tdata = {6'b000000, result.operand_in_register, result.effective_address,
                    result.moved_value, result.ok};

endmodule
